// File: design/rtos_pkg.sv
// package: shared types and codes for the ready/delay task scheduler
`default_nettype none
package rtos_pkg;

  localparam int unsigned IdW = 4;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELAY  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_SWITCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_LISTED = 2'd1,
    ERR_EMPTY  = 2'd2,
    ERR_FULL   = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RSCAN,
    ST_RSHIFT,
    ST_RPUT,
    ST_POP,
    ST_DHEAD,
    ST_DADJ,
    ST_DSCAN,
    ST_DSHIFT,
    ST_DPUT,
    ST_WPOP,
    ST_WREBASE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] delay_ticks;
  } sched_in_t;

  typedef struct packed {
    logic [3:0] current_task;
    logic       current_valid;
    logic [3:0] ready_head;
    logic       ready_valid;
    logic       switch_needed;
    logic [3:0] woken_task;
    logic       woken_valid;
    logic [1:0] error;
  } sched_out_t;

endpackage
`default_nettype wire

// File: design/rtos_ready_and_delay_scheduler.sv
// top level: task scheduler with priority ready list and delta delay list
// one item at a time: busy is high from acceptance until the result strobe.
// the list walks run one entry per cycle; delay walks share one add/sub unit.
// reset clears counts, listed flags and the running task; list storage is
// left undefined and never read before being written.
`default_nettype none
module rtos_ready_and_delay_scheduler
  import rtos_pkg::*;
#(
  parameter int unsigned MAX_TASKS     = 16,
  parameter int unsigned DELAY_BITS    = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire sched_in_t  item_i,
  output logic            done_o,
  output sched_out_t      result_o
);

  localparam int unsigned PosW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned NId  = 16;
  localparam logic [DELAY_BITS-1:0] DMax = {DELAY_BITS{1'b1}};
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TASKS);

  state_e state_q, state_d;

  logic [IdW-1:0]           rord_q  [MAX_TASKS];
  logic [IdW-1:0]           dord_q  [MAX_TASKS];
  logic [DELAY_BITS-1:0]    drel_q  [MAX_TASKS];
  logic [PRIORITY_BITS-1:0] prio_q  [NId];
  logic [NId-1:0]           listed_q;
  logic [CntW-1:0]          rcnt_q, dcnt_q;
  logic [IdW-1:0]           run_q;
  logic                     runv_q;

  // working registers
  logic [CntW-1:0]       idx_q;
  logic [CntW-1:0]       pos_q;
  logic [IdW-1:0]        tsk_q;
  logic [DELAY_BITS-1:0] d_q;
  logic [DELAY_BITS-1:0] t_q;
  logic [1:0]            err_q;
  logic                  wk_q;
  logic [IdW-1:0]        wid_q;
  sched_out_t            res_q;
  logic                  done_q;

  logic [PosW-1:0] ip, im1;
  assign ip  = idx_q[PosW-1:0];
  assign im1 = PosW'(idx_q - 1'b1);

  // shared arithmetic unit: one add/sub and compare per cycle
  // at the delay head: new delay against the head count
  logic [DELAY_BITS:0]   sum;
  logic [DELAY_BITS-1:0] sub_a, sub_b, diff;
  logic                  ge;
  always_comb begin
    sum   = {1'b0, drel_q[ip]} + {1'b0, t_q};
    sub_a = (state_q == ST_DHEAD) ? d_q : drel_q[ip];
    sub_b = (state_q == ST_DHEAD) ? drel_q[0] : t_q;
    ge    = sub_a >= sub_b;
    diff  = sub_a - sub_b;
  end

  logic [IdW-1:0] in_id;
  assign in_id = item_i.task_id;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_e'(item_i.command))
            CMD_CREATE: begin
              if (!listed_q[in_id] && (rcnt_q + dcnt_q) < CntMax) state_d = ST_RSCAN;
              else state_d = ST_DONE;
            end
            CMD_DELAY:  state_d = (rcnt_q == '0) ? ST_DONE : ST_POP;
            CMD_TICK: begin
              if (dcnt_q == '0) state_d = ST_DONE;
              else if (drel_q[0] == '0) state_d = ST_WPOP;
              else state_d = ST_DONE;
            end
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_RSCAN: begin
        if (idx_q >= rcnt_q || prio_q[rord_q[ip]] < prio_q[tsk_q]) state_d = ST_RSHIFT;
      end
      ST_RSHIFT: if (idx_q <= pos_q) state_d = ST_RPUT;
      ST_RPUT:   state_d = ST_DONE;
      ST_POP:    if (idx_q >= rcnt_q) state_d = ST_DHEAD;
      ST_DHEAD: begin
        if (dcnt_q == '0) state_d = ST_DSHIFT;
        else if (!ge) state_d = ST_DADJ;
        else state_d = ST_DSCAN;
      end
      ST_DADJ:   if (idx_q >= dcnt_q) state_d = ST_DSHIFT;
      ST_DSCAN:  if (idx_q >= dcnt_q || drel_q[ip] > d_q) state_d = ST_DSHIFT;
      ST_DSHIFT: if (idx_q <= pos_q) state_d = ST_DPUT;
      ST_DPUT:   state_d = ST_DONE;
      ST_WPOP:   if (idx_q >= dcnt_q) state_d = ST_WREBASE;
      ST_WREBASE: if (idx_q >= dcnt_q) state_d = ST_RSCAN;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = (state_q != ST_IDLE);
    done_o   = done_q;
    result_o = res_q;
  end

  // datapath and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      listed_q <= '0;
      rcnt_q   <= '0;
      dcnt_q   <= '0;
      run_q    <= '0;
      runv_q   <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
      pos_q    <= '0;
      err_q    <= ERR_OK;
      wk_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          wk_q <= 1'b0;
          if (start) begin
            unique case (cmd_e'(item_i.command))
              CMD_CREATE: begin
                idx_q <= '0;
                if (listed_q[in_id]) err_q <= ERR_LISTED;
                else if ((rcnt_q + dcnt_q) >= CntMax) err_q <= ERR_FULL;
                else begin
                  err_q           <= ERR_OK;
                  prio_q[in_id]   <= item_i.priority_req[PRIORITY_BITS-1:0];
                  listed_q[in_id] <= 1'b1;
                  tsk_q           <= in_id;
                end
              end
              CMD_DELAY: begin
                idx_q <= CntW'(1);
                if (rcnt_q == '0) err_q <= ERR_EMPTY;
                else begin
                  err_q <= ERR_OK;
                  tsk_q <= rord_q[0];
                  d_q   <= DELAY_BITS'(item_i.delay_ticks);
                end
              end
              CMD_TICK: begin
                err_q <= ERR_OK;
                idx_q <= CntW'(1);
                if (dcnt_q != '0) begin
                  if (drel_q[0] == '0) tsk_q <= dord_q[0];
                  else drel_q[0] <= drel_q[0] - 1'b1;
                end
              end
              default: begin
                err_q  <= ERR_OK;
                runv_q <= (rcnt_q != '0);
                run_q  <= (rcnt_q != '0) ? rord_q[0] : '0;
              end
            endcase
          end
        end
        ST_RSCAN: begin
          if (idx_q >= rcnt_q || prio_q[rord_q[ip]] < prio_q[tsk_q]) begin
            pos_q <= idx_q;
            idx_q <= rcnt_q;
          end else idx_q <= idx_q + 1'b1;
        end
        ST_RSHIFT: begin
          if (idx_q > pos_q) begin
            rord_q[ip] <= rord_q[im1];
            idx_q      <= idx_q - 1'b1;
          end
        end
        ST_RPUT: begin
          rord_q[pos_q[PosW-1:0]] <= tsk_q;
          rcnt_q <= rcnt_q + 1'b1;
        end
        ST_POP: begin
          if (idx_q < rcnt_q) begin
            rord_q[im1] <= rord_q[ip];
            idx_q       <= idx_q + 1'b1;
          end else begin
            rcnt_q <= rcnt_q - 1'b1;
            idx_q  <= CntW'(1);
          end
        end
        ST_DHEAD: begin
          if (dcnt_q == '0) begin
            pos_q <= '0;
            idx_q <= '0;
          end else if (!ge) begin
            t_q       <= drel_q[0] - d_q;
            drel_q[0] <= drel_q[0] - d_q;
          end else begin
            d_q <= diff;
          end
        end
        ST_DADJ: begin
          if (idx_q < dcnt_q) begin
            drel_q[ip] <= sum[DELAY_BITS] ? DMax : sum[DELAY_BITS-1:0];
            idx_q      <= idx_q + 1'b1;
          end else begin
            pos_q <= '0;
            idx_q <= dcnt_q;
          end
        end
        ST_DSCAN: begin
          if (idx_q >= dcnt_q || drel_q[ip] > d_q) begin
            pos_q <= idx_q;
            idx_q <= dcnt_q;
          end else idx_q <= idx_q + 1'b1;
        end
        ST_DSHIFT: begin
          if (idx_q > pos_q) begin
            dord_q[ip] <= dord_q[im1];
            drel_q[ip] <= drel_q[im1];
            idx_q      <= idx_q - 1'b1;
          end
        end
        ST_DPUT: begin
          dord_q[pos_q[PosW-1:0]] <= tsk_q;
          drel_q[pos_q[PosW-1:0]] <= d_q;
          dcnt_q <= dcnt_q + 1'b1;
        end
        ST_WPOP: begin
          if (idx_q < dcnt_q) begin
            dord_q[im1] <= dord_q[ip];
            drel_q[im1] <= drel_q[ip];
            idx_q       <= idx_q + 1'b1;
          end else begin
            dcnt_q <= dcnt_q - 1'b1;
            t_q    <= drel_q[0];
            idx_q  <= CntW'(1);
            wk_q   <= 1'b1;
            wid_q  <= tsk_q;
          end
        end
        ST_WREBASE: begin
          if (idx_q < dcnt_q) begin
            drel_q[ip] <= ge ? diff : '0;
            idx_q      <= idx_q + 1'b1;
          end else idx_q <= '0;
        end
        ST_DONE: begin
          done_q              <= 1'b1;
          res_q.current_task  <= runv_q ? run_q : '0;
          res_q.current_valid <= runv_q;
          res_q.ready_head    <= (rcnt_q != '0) ? rord_q[0] : '0;
          res_q.ready_valid   <= (rcnt_q != '0);
          res_q.switch_needed <= ((rcnt_q != '0) != runv_q) ||
                                 ((rcnt_q != '0) && rord_q[0] != run_q);
          res_q.woken_task    <= wk_q ? wid_q : '0;
          res_q.woken_valid   <= wk_q;
          res_q.error         <= err_q;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // list occupancy never exceeds capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rcnt_q + dcnt_q) <= CntMax) else $error("list overflow");
  // result strobe only after the done state
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_DONE)) else $error("stray result");
  // an accepted item always yields busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item dropped");
`endif

endmodule
`default_nettype wire

// File: sim/rtos_ready_and_delay_scheduler_tb.sv
// testbench: random and directed command streams against a scheduler predictor
`default_nettype none
module rtos_ready_and_delay_scheduler_tb;
  import rtos_pkg::*;

  localparam int unsigned NTASK = 16;
  localparam int unsigned DMAX = 65535;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  sched_in_t item_i = '0;
  logic done_o;
  sched_out_t result_o;

  rtos_ready_and_delay_scheduler uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [3:0]  rdy_ids[NTASK];
  int unsigned rdy_n;
  logic [3:0]  dly_ids[NTASK];
  int unsigned dly_rel[NTASK];
  int unsigned dly_n;
  logic [7:0]  prio_of[NTASK];
  bit          listed[NTASK];
  logic [3:0]  run_id;
  bit          run_v;

  sched_out_t  view_q[$];
  int          n_err = 0;
  int          n_sent = 0;
  int          n_seen = 0;
  int          n_woke = 0;

  function automatic void rdy_put(logic [3:0] t);
    int unsigned p;
    p = 0;
    if (rdy_n >= NTASK) return;
    while (p < rdy_n && prio_of[rdy_ids[p]] >= prio_of[t]) p++;
    for (int unsigned i = rdy_n; i > p; i--) rdy_ids[i] = rdy_ids[i-1];
    rdy_ids[p] = t;
    rdy_n++;
  endfunction

  function automatic void dly_put(logic [3:0] t, int unsigned d);
    int unsigned p, k;
    longint unsigned s;
    if (dly_n >= NTASK) return;
    if (dly_n == 0) p = 0;
    else if (dly_rel[0] > d) begin
      k = dly_rel[0] - d;
      dly_rel[0] = k;
      for (int unsigned i = 1; i < dly_n; i++) begin
        s = longint'(dly_rel[i]) + k;
        dly_rel[i] = (s > DMAX) ? DMAX : int'(s);
      end
      p = 0;
    end else begin
      d -= dly_rel[0];
      p = 1;
      while (p < dly_n && dly_rel[p] <= d) p++;
    end
    for (int unsigned i = dly_n; i > p; i--) begin
      dly_ids[i] = dly_ids[i-1];
      dly_rel[i] = dly_rel[i-1];
    end
    dly_ids[p] = t;
    dly_rel[p] = d;
    dly_n++;
  endfunction

  // next scheduler view for one command
  function automatic sched_out_t sched_view(sched_in_t it);
    sched_out_t o;
    logic [3:0] t;
    int unsigned base;
    o = '0;
    o.error = ERR_OK;
    case (cmd_e'(it.command))
      CMD_CREATE: begin
        if (listed[it.task_id]) o.error = ERR_LISTED;
        else if (rdy_n + dly_n >= NTASK) o.error = ERR_FULL;
        else begin
          prio_of[it.task_id] = it.priority_req;
          listed[it.task_id] = 1'b1;
          rdy_put(it.task_id);
        end
      end
      CMD_DELAY: begin
        if (rdy_n == 0) o.error = ERR_EMPTY;
        else begin
          t = rdy_ids[0];
          for (int unsigned i = 1; i < rdy_n; i++) rdy_ids[i-1] = rdy_ids[i];
          rdy_n--;
          dly_put(t, it.delay_ticks);
        end
      end
      CMD_TICK: begin
        if (dly_n > 0) begin
          if (dly_rel[0] == 0) begin
            t = dly_ids[0];
            for (int unsigned i = 1; i < dly_n; i++) begin
              dly_ids[i-1] = dly_ids[i];
              dly_rel[i-1] = dly_rel[i];
            end
            dly_n--;
            if (dly_n > 0) begin
              base = dly_rel[0];
              for (int unsigned i = 1; i < dly_n; i++)
                dly_rel[i] = (dly_rel[i] >= base) ? dly_rel[i] - base : 0;
            end
            rdy_put(t);
            o.woken_task = t;
            o.woken_valid = 1'b1;
          end else dly_rel[0]--;
        end
      end
      default: begin
        run_v = rdy_n > 0;
        run_id = run_v ? rdy_ids[0] : 4'd0;
      end
    endcase
    o.current_task = run_v ? run_id : 4'd0;
    o.current_valid = run_v;
    o.ready_valid = rdy_n > 0;
    o.ready_head = (rdy_n > 0) ? rdy_ids[0] : 4'd0;
    o.switch_needed = (o.ready_valid != run_v) ||
                      (o.ready_valid && o.ready_head != run_id);
    return o;
  endfunction

  // burst/gap pacing of the sender
  int burst_left = 0;

  // start stays high until the next item or a gap; busy blocks repeats
  task automatic send_item(sched_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        item_i <= '0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    view_q.push_back(sched_view(it));
    n_sent++;
    if (it.command == CMD_TICK && view_q[$].woken_valid) n_woke++;
  endtask

  function automatic sched_in_t mk(cmd_e c, logic [3:0] id, logic [7:0] p,
                                   logic [15:0] d);
    sched_in_t it;
    it.command = c;
    it.task_id = id;
    it.priority_req = p;
    it.delay_ticks = d;
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_seen++;
      if (view_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        n_err++;
      end else begin
        sched_out_t e;
        e = view_q.pop_front();
        if (e !== result_o) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, result_o);
          n_err++;
        end
      end
    end
  end

  // extremes, every command and the listed and empty error cases
  task automatic test_directed();
    send_item(mk(CMD_TICK, 4'd0, 8'd0, 16'd0));
    send_item(mk(CMD_SWITCH, 4'd0, 8'd0, 16'd0));
    send_item(mk(CMD_DELAY, 4'd0, 8'd0, 16'd0));
    send_item(mk(CMD_CREATE, 4'd15, 8'd255, 16'hffff));
    send_item(mk(CMD_CREATE, 4'd15, 8'd1, 16'd0));
    send_item(mk(CMD_CREATE, 4'd0, 8'd0, 16'd0));
    send_item(mk(CMD_CREATE, 4'd5, 8'd255, 16'd0));
    send_item(mk(CMD_SWITCH, 4'd0, 8'd0, 16'd0));
    send_item(mk(CMD_DELAY, 4'd0, 8'd0, 16'hffff));
    send_item(mk(CMD_DELAY, 4'd0, 8'd0, 16'd0));
    send_item(mk(CMD_DELAY, 4'd0, 8'd0, 16'd2));
    send_item(mk(CMD_SWITCH, 4'd0, 8'd0, 16'd0));
    repeat (4) send_item(mk(CMD_TICK, 4'd0, 8'd0, 16'd0));
    send_item(mk(CMD_CREATE, 4'd5, 8'd3, 16'd0));
    for (int i = 1; i < 15; i++)
      send_item(mk(CMD_CREATE, 4'(i), 8'(i * 17), 16'd0));
  endtask

  // fill the lists with mixed delays including saturating ones
  task automatic test_fill_saturate();
    for (int i = 0; i < 14; i++)
      send_item(mk(CMD_DELAY, 4'd0, 8'd0, (i % 3 == 0) ? 16'hffff : 16'($urandom_range(0, 3))));
    send_item(mk(CMD_CREATE, 4'd3, 8'd0, 16'd0));
    repeat (40) send_item(mk(CMD_TICK, 4'd0, 8'd0, 16'd0));
  endtask

  // weighted random commands with small delays so tasks cycle through
  task automatic test_random(int count);
    sched_in_t it;
    for (int i = 0; i < count; i++) begin
      it.task_id = 4'($urandom);
      it.priority_req = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      it.delay_ticks = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      case ($urandom_range(0, 9))
        0, 1, 2: it.command = CMD_CREATE;
        3, 4:    it.command = CMD_DELAY;
        5, 6, 7: it.command = CMD_TICK;
        default: it.command = CMD_SWITCH;
      endcase
      send_item(it);
    end
  endtask

  initial begin
    rdy_n = 0;
    dly_n = 0;
    run_id = '0;
    run_v = 0;
    foreach (listed[i]) listed[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_saturate();
    test_random(580);
    start <= 1'b0;
    item_i <= '0;
    while (view_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("ran %0d commands, %0d results checked, %0d wakeups", n_sent, n_seen, n_woke);
    if (n_err == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
design/rtos_pkg.sv
design/rtos_ready_and_delay_scheduler.sv
sim/rtos_ready_and_delay_scheduler_tb.sv
